@@ src/julian_day_calendar_converter_assert.svh @@
// Assertion macros shared by the converter's checker.
`ifndef JULIAN_DAY_CALENDAR_CONVERTER_ASSERT_SVH
`define JULIAN_DAY_CALENDAR_CONVERTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define JDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define JDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/jdc_pkg.sv @@
// Types and constants of the Julian Day Number calendar converter.
`default_nettype none
package jdc_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;

	localparam int YEAR_W = 15;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;
	localparam int DN_W   = 23;
	localparam int WD_W   = 3;

	// Working widths: year with headroom, day with room for 32, formula result.
	localparam int YW_W  = 17;
	localparam int DW_W  = 6;
	localparam int RES_W = 26;
	localparam int CNT_W = 9;

	localparam int YEAR_STEPS  = 400;
	localparam int MONTH_STEPS = 12;
	localparam int DAY_STEPS   = 31;

	localparam logic signed [YEAR_W-1:0] YEAR_SAT = 15'sd16383;
	localparam logic [DN_W-1:0] DN_MAX = 23'd8388607;

	typedef enum logic [1:0] {
		EV_DATE,
		EV_YEAR,
		EV_MONTH,
		EV_DAY
	} ev_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_FWD_WAIT,
		ST_Y_ISSUE,
		ST_Y_WAIT,
		ST_M_ISSUE,
		ST_M_WAIT,
		ST_D_ISSUE,
		ST_D_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    cap;
		logic    ev_go;
		ev_sel_t ev_sel;
		logic    y_init;
		logic    y_inc;
		logic    m_init;
		logic    m_inc;
		logic    d_init;
		logic    d_inc;
		logic    jd_ld;
		logic    out_ld;
	} jdc_cmd_t;

	typedef struct packed {
		logic inverse;
		logic ev_valid;
		logic ev_le;
		logic n_lt_year;
		logic n_lt_month;
		logic n_lt_day;
		logic out_full;
	} jdc_stat_t;

endpackage
`default_nettype wire

@@ src/jdc_eval.sv @@
// Three-stage pipelined evaluator of the date to day number formula.
`default_nettype none
module jdc_eval (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            go,
	input  wire logic                            greg,
	input  wire logic signed [jdc_pkg::YW_W-1:0]  y,
	input  wire logic [jdc_pkg::MON_W-1:0]        m,
	input  wire logic [jdc_pkg::DW_W-1:0]         d,
	output logic                                 vld,
	output logic signed [jdc_pkg::RES_W-1:0]      res
);
	import jdc_pkg::*;

	localparam logic [15:0] RECIP_25 = 16'd41944;

	// Month term 30*M + (3M+2)/5 after the March shift; equal for both calendars.
	function automatic logic [8:0] month_term(input logic [MON_W-1:0] mm);
		logic [8:0] t;
		case (mm)
			4'd0:    t = 9'd275;
			4'd1:    t = 9'd306;
			4'd2:    t = 9'd337;
			4'd3:    t = 9'd0;
			4'd4:    t = 9'd31;
			4'd5:    t = 9'd61;
			4'd6:    t = 9'd92;
			4'd7:    t = 9'd122;
			4'd8:    t = 9'd153;
			4'd9:    t = 9'd184;
			4'd10:   t = 9'd214;
			4'd11:   t = 9'd245;
			4'd12:   t = 9'd275;
			4'd13:   t = 9'd306;
			4'd14:   t = 9'd337;
			default: t = 9'd367;
		endcase
		return t;
	endfunction

	logic [2:0] vld_q;

	// stage 1
	logic signed [YW_W-1:0] y_adj, y_base;
	logic [YW_W-1:0]        y_mag;
	logic signed [YW_W-1:0] ybase_s1;
	logic                   neg_s1, greg_s1;
	logic [YW_W-3:0]        a4_s1;
	logic [8:0]             mt_s1;
	logic [DW_W-1:0]        d_s1;

	assign y_adj  = (m < 4'd3) ? y - 17'sd1 : y;
	assign y_base = y_adj + (greg ? 17'sd8000 : 17'sd4800);
	assign y_mag  = y_base[YW_W-1] ? $unsigned(-y_base) : $unsigned(y_base);

	always_ff @(posedge clk) begin
		ybase_s1 <= y_base;
		neg_s1   <= y_base[YW_W-1];
		a4_s1    <= y_mag[YW_W-1:2];
		mt_s1    <= month_term(m);
		d_s1     <= d;
		greg_s1  <= greg;
	end

	// stage 2
	logic signed [RES_W-1:0] y_ext, p365;
	logic [30:0]             prod100;
	logic [10:0]             q100, q400;
	logic [YW_W-3:0]         leap_mag;
	logic signed [YW_W-1:0]  leap;
	logic signed [RES_W-1:0] p365_s2;
	logic signed [YW_W-1:0]  leap_s2;
	logic [8:0]              mt_s2;
	logic [DW_W-1:0]         d_s2;
	logic                    greg_s2;

	assign y_ext    = {{(RES_W-YW_W){ybase_s1[YW_W-1]}}, ybase_s1};
	assign p365     = y_ext * 26'sd365;
	// |Y|/100 as (|Y|/4)/25 by reciprocal, exact for the operand range here.
	assign prod100  = 31'(a4_s1) * 31'(RECIP_25);
	assign q100     = prod100[30:20];
	assign q400     = q100 >> 2;
	assign leap_mag = greg_s1 ? a4_s1 - 15'(q100) + 15'(q400) : a4_s1;
	assign leap     = neg_s1 ? -$signed({2'b00, leap_mag}) : $signed({2'b00, leap_mag});

	always_ff @(posedge clk) begin
		p365_s2 <= p365;
		leap_s2 <= leap;
		mt_s2   <= mt_s1;
		d_s2    <= d_s1;
		greg_s2 <= greg_s1;
	end

	// stage 3
	logic signed [RES_W-1:0] sum;

	assign sum = p365_s2
		+ {{(RES_W-YW_W){leap_s2[YW_W-1]}}, leap_s2}
		+ $signed({17'd0, mt_s2})
		+ $signed({20'd0, d_s2})
		+ (greg_s2 ? -26'sd1200821 : -26'sd32083);

	always_ff @(posedge clk) begin
		res <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], go};
		end
	end

	assign vld = vld_q[2];

endmodule
`default_nettype wire

@@ src/jdc_datapath.sv @@
// Datapath: item registers, search registers, evaluator and output register.
`default_nettype none
module jdc_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [jdc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic [jdc_pkg::IN_USER_W-1:0]    s_tuser,
	input  wire logic                             m_tready,
	input  wire jdc_pkg::jdc_cmd_t                cmd,
	output jdc_pkg::jdc_stat_t                    stat,
	output logic                                  m_tvalid,
	output logic [jdc_pkg::OUT_DATA_W-1:0]        m_tdata
);
	import jdc_pkg::*;

	localparam logic [22:0] RECIP_183 = 23'd5867442;

	// Day number mod 7 by folding octal digits (8 = 1 mod 7).
	function automatic logic [WD_W-1:0] mod7(input logic [DN_W-1:0] v);
		logic [23:0] x;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [2:0]  s3;
		x  = {1'b0, v};
		s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
			+ 6'(x[14:12]) + 6'(x[17:15]) + 6'(x[20:18]) + 6'(x[23:21]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		s3 = 3'(s2[2:0]) + 3'(s2[3]);
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

	logic                   act_q, cal_q;
	logic signed [YW_W-1:0] y_q;
	logic [MON_W-1:0]       m_q;
	logic [DW_W-1:0]        d_q;
	logic [DN_W-1:0]        jd_q;
	logic [CNT_W-1:0]       n_q;
	logic [44:0]            prod_q;
	logic                   out_vld_q;
	logic [OUT_DATA_W-1:0]  out_q;

	logic                    ev_vld;
	logic signed [RES_W-1:0] ev_res;
	logic signed [YW_W-1:0]  ev_y;
	logic [MON_W-1:0]        ev_m;
	logic [DW_W-1:0]         ev_d;

	always_comb begin
		case (cmd.ev_sel)
			EV_DATE: begin
				ev_y = y_q;
				ev_m = m_q;
				ev_d = d_q;
			end
			EV_YEAR: begin
				ev_y = y_q + 17'sd1;
				ev_m = 4'd1;
				ev_d = 6'd1;
			end
			EV_MONTH: begin
				ev_y = y_q;
				ev_m = m_q + 4'd1;
				ev_d = 6'd1;
			end
			default: begin
				ev_y = y_q;
				ev_m = m_q;
				ev_d = d_q + 6'd1;
			end
		endcase
	end

	jdc_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.ev_go),
		.greg   (cal_q),
		.y      (ev_y),
		.m      (ev_m),
		.d      (ev_d),
		.vld    (ev_vld),
		.res    (ev_res)
	);

	logic [DN_W-1:0] jd_sat;

	always_comb begin
		if (ev_res[RES_W-1]) begin
			jd_sat = '0;
		end else if (ev_res[RES_W-2:DN_W] != '0) begin
			jd_sat = DN_MAX;
		end else begin
			jd_sat = ev_res[DN_W-1:0];
		end
	end

	// day_number / 366 as (day_number / 2) / 183 by reciprocal
	always_ff @(posedge clk) begin
		prod_q <= 45'(jd_q[DN_W-1:1]) * 45'(RECIP_183);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q <= s_tuser[0];
			cal_q <= s_tuser[1];
			y_q   <= {{(YW_W-YEAR_W){s_tdata[14]}}, s_tdata[14:0]};
			m_q   <= s_tdata[18:15];
			d_q   <= {1'b0, s_tdata[23:19]};
			jd_q  <= s_tdata[46:24];
		end
		if (cmd.jd_ld) begin
			jd_q <= jd_sat;
		end
		if (cmd.y_init) begin
			y_q <= $signed({2'b00, prod_q[44:30]}) - 17'sd4715;
			n_q <= '0;
		end
		if (cmd.y_inc) begin
			y_q <= y_q + 17'sd1;
			n_q <= n_q + 9'd1;
		end
		if (cmd.m_init) begin
			m_q <= 4'd1;
			n_q <= '0;
		end
		if (cmd.m_inc) begin
			m_q <= m_q + 4'd1;
			n_q <= n_q + 9'd1;
		end
		if (cmd.d_init) begin
			d_q <= 6'd1;
			n_q <= '0;
		end
		if (cmd.d_inc) begin
			d_q <= d_q + 6'd1;
			n_q <= n_q + 9'd1;
		end
	end

	// Clamp a year past the output range to the last day of year 16383.
	logic                    y_over;
	logic [YEAR_W-1:0]       o_year;
	logic [MON_W-1:0]        o_mon;
	logic [DAY_W-1:0]        o_day;

	assign y_over = (y_q > 17'sd16383);
	assign o_year = y_over ? YEAR_SAT : y_q[YEAR_W-1:0];
	assign o_mon  = y_over ? 4'd12 : m_q;
	assign o_day  = y_over ? 5'd31 : d_q[DAY_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q <= {6'd0, mod7(jd_q), o_day, o_mon, o_year, jd_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	assign stat.inverse    = act_q;
	assign stat.ev_valid   = ev_vld;
	assign stat.ev_le      = (ev_res <= $signed({3'b000, jd_q}));
	assign stat.n_lt_year  = (n_q < CNT_W'(YEAR_STEPS));
	assign stat.n_lt_month = (n_q < CNT_W'(MONTH_STEPS));
	assign stat.n_lt_day   = (n_q < CNT_W'(DAY_STEPS));
	assign stat.out_full   = out_vld_q;

endmodule
`default_nettype wire

@@ src/jdc_ctrl.sv @@
// Controller state machine sequencing the forward formula and the upward search.
`default_nettype none
module jdc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                m_tready,
	input  wire jdc_pkg::jdc_stat_t  stat,
	output logic                     s_tready,
	output jdc_pkg::jdc_cmd_t        cmd
);
	import jdc_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_nx = ST_START;
			ST_START:    state_nx = stat.inverse ? ST_DIV : ST_FWD_WAIT;
			ST_DIV:      state_nx = ST_Y_ISSUE;
			ST_FWD_WAIT: if (stat.ev_valid) state_nx = ST_DONE;
			ST_Y_ISSUE:  state_nx = ST_Y_WAIT;
			ST_Y_WAIT: begin
				if (stat.ev_valid) begin
					state_nx = (stat.n_lt_year && stat.ev_le) ? ST_Y_ISSUE : ST_M_ISSUE;
				end
			end
			ST_M_ISSUE:  state_nx = ST_M_WAIT;
			ST_M_WAIT: begin
				if (stat.ev_valid) begin
					state_nx = (stat.n_lt_month && stat.ev_le) ? ST_M_ISSUE : ST_D_ISSUE;
				end
			end
			ST_D_ISSUE:  state_nx = ST_D_WAIT;
			ST_D_WAIT: begin
				if (stat.ev_valid) begin
					state_nx = (stat.n_lt_day && stat.ev_le) ? ST_D_ISSUE : ST_DONE;
				end
			end
			ST_DONE:     if (!stat.out_full || m_tready) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.ev_sel = EV_DATE;
		s_tready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.cap  = s_tvalid;
			end
			ST_START: begin
				cmd.ev_go  = !stat.inverse;
				cmd.ev_sel = EV_DATE;
			end
			ST_DIV: begin
				cmd.y_init = 1'b1;
			end
			ST_FWD_WAIT: begin
				cmd.jd_ld = stat.ev_valid;
			end
			ST_Y_ISSUE: begin
				cmd.ev_go  = 1'b1;
				cmd.ev_sel = EV_YEAR;
			end
			ST_Y_WAIT: begin
				if (stat.ev_valid) begin
					cmd.y_inc  = stat.n_lt_year && stat.ev_le;
					cmd.m_init = !(stat.n_lt_year && stat.ev_le);
				end
			end
			ST_M_ISSUE: begin
				cmd.ev_go  = 1'b1;
				cmd.ev_sel = EV_MONTH;
			end
			ST_M_WAIT: begin
				if (stat.ev_valid) begin
					cmd.m_inc  = stat.n_lt_month && stat.ev_le;
					cmd.d_init = !(stat.n_lt_month && stat.ev_le);
				end
			end
			ST_D_ISSUE: begin
				cmd.ev_go  = 1'b1;
				cmd.ev_sel = EV_DAY;
			end
			ST_D_WAIT: begin
				if (stat.ev_valid) begin
					cmd.d_inc = stat.n_lt_day && stat.ev_le;
				end
			end
			ST_DONE: begin
				cmd.out_ld = !stat.out_full || m_tready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/julian_day_calendar_converter.sv @@
// Top level of the Julian Day Number calendar converter.
//
//   channel  dir  width        meaning
//   s_*      in   48 + 2 user  one request: a date or a day number to convert
//   m_*      out  56           one result: day number, date and weekday
//
// Forward requests (date to day number) run the formula once. Inverse requests
// run an upward search in year, month and day steps; every evaluation is an
// issue state followed by the evaluator pipeline, the step being decided as the
// result appears.
// Present-day day numbers need about 17 year steps, the top of the 23-bit range
// about 50; a search takes at most 11 month and 30 day steps.
// Reset is asynchronous and active low; it clears the controller, the evaluator
// valid pipe and the result valid flag.
// A new request is taken as soon as the previous result sits in the output
// register, even while m_tready stalls it.
`default_nettype none
module julian_day_calendar_converter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// year[14:0], month[18:15], day[23:19], day_number[46:24], zero[47]
	input  wire logic [jdc_pkg::IN_DATA_W-1:0]   s_tdata,
	// action[0], calendar[1]
	input  wire logic [jdc_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_day_number[22:0], out_year[37:23], out_month[41:38], out_day[46:42],
	// weekday[49:47], zero[55:50]
	output logic [jdc_pkg::OUT_DATA_W-1:0]       m_tdata
);
	import jdc_pkg::*;

	jdc_cmd_t  cmd;
	jdc_stat_t stat;

	// Sequence each request: capture, evaluate or search, then hand off.
	jdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	// Hold the request, run the formula, and drive the result register.
	jdc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

@@ src/jdc_checker.sv @@
// Port-level checker for the converter, bound to the top level.
`default_nettype none
`include "julian_day_calendar_converter_assert.svh"
module jdc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [jdc_pkg::OUT_DATA_W-1:0] m_tdata
);
	logic       in_take;
	logic       out_stall;
	logic [2:0] out_wd;
	logic [5:0] out_pad;

	assign in_take   = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;
	assign out_wd    = m_tdata[49:47];
	assign out_pad   = m_tdata[55:50];

	`JDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid, "result dropped")
	`JDC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(m_tdata), "result changed")
	`JDC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_take, !s_tready, "taken while busy")
	`JDC_ASSERT_SAME(a_weekday_range, clk, arst_n, m_tvalid, out_wd != 3'd7, "bad weekday")
	`JDC_ASSERT_SAME(a_pad_zero, clk, arst_n, m_tvalid, out_pad == '0, "padding not zero")

endmodule

bind julian_day_calendar_converter jdc_checker u_jdc_checker (.*);
`default_nettype wire

@@ tb/sv/tb_julian_day_calendar_converter.sv @@
// Self-checking testbench for the Julian Day Number calendar converter.
`timescale 1ns / 100ps
module tb_julian_day_calendar_converter;

	// Request kinds and calendars as they travel in s_tuser.
	localparam logic ACT_TO_DAY_NUMBER = 1'b0;
	localparam logic ACT_TO_DATE       = 1'b1;
	localparam logic CAL_JULIAN        = 1'b0;
	localparam logic CAL_GREGORIAN     = 1'b1;

	// Saturation bounds of the result fields.
	localparam longint DAY_NUMBER_CEIL = 64'd8388607;
	localparam longint YEAR_CEIL       = 64'd16383;

	// Search step caps of the day number to date conversion.
	localparam int YEAR_STEP_CAP  = 400;
	localparam int MONTH_STEP_CAP = 12;
	localparam int DAY_STEP_CAP   = 31;

	localparam int LONG_HOLD_CYCLES = 200;
	localparam int REPORT_LIMIT     = 10;

	typedef struct {
		logic              action;
		logic              calendar;
		logic signed [14:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [22:0]       day_number;
	} conv_request_t;

	typedef struct {
		logic [22:0]        day_number;
		logic signed [14:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [2:0]         weekday;
	} conv_result_t;

	logic                           clk;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	// year[14:0], month[18:15], day[23:19], day_number[46:24], zero[47]
	logic [jdc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	// action[0], calendar[1]
	logic [jdc_pkg::IN_USER_W-1:0]  s_tuser  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	// out_day_number[22:0], out_year[37:23], out_month[41:38], out_day[46:42],
	// weekday[49:47], zero[55:50]
	logic [jdc_pkg::OUT_DATA_W-1:0] m_tdata;

	// Results still owed by the block, oldest first.
	conv_result_t pending_conversions[$];

	int  mismatch_count   = 0;
	int  results_checked  = 0;
	int  dates_converted  = 0;
	int  numbers_converted = 0;
	int  clamped_count    = 0;
	bit  quiet_run        = 1'b0;
	bit  long_hold_req    = 1'b0;

	julian_day_calendar_converter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Closed-form day number of a date; divisions truncate toward zero just
	// like SystemVerilog's own signed division, so no correction is needed.
	function automatic longint day_number_of(logic greg, longint y, longint m, longint d);
		if (m < 3) begin
			y = y - 1;
			m = m + 12;
		end
		if (greg) begin
			y = y + 8000;
			return y * 365 + y / 4 - y / 100 + y / 400
				+ (m * 153 + 3) / 5 - 92 + d - 1 - 1200820;
		end
		y = y + 4800;
		m = m - 3;
		return y * 365 + y / 4 + 30 * m + (m * 3 + 2) / 5 + d - 32083;
	endfunction

	// Work out the one result that a request produces.
	function automatic conv_result_t convert_request(conv_request_t rq);
		conv_result_t r;
		longint jd, y, m, d, wd;
		int n;
		if (rq.action == ACT_TO_DAY_NUMBER) begin
			y  = longint'(rq.year);
			m  = longint'(rq.month);
			d  = longint'(rq.day);
			jd = day_number_of(rq.calendar, y, m, d);
			// clamp into the 23-bit day number range
			if (jd < 0)
				jd = 0;
			if (jd > DAY_NUMBER_CEIL)
				jd = DAY_NUMBER_CEIL;
		end else begin
			jd = longint'(rq.day_number);
			// start low and walk up year, month, day while the next one still fits
			y = jd / 366 - 4715;
			for (n = 0; n < YEAR_STEP_CAP && day_number_of(rq.calendar, y + 1, 1, 1) <= jd; n++)
				y = y + 1;
			m = 1;
			for (n = 0; n < MONTH_STEP_CAP && day_number_of(rq.calendar, y, m + 1, 1) <= jd; n++)
				m = m + 1;
			d = 1;
			for (n = 0; n < DAY_STEP_CAP && day_number_of(rq.calendar, y, m, d + 1) <= jd; n++)
				d = d + 1;
			// years past the output range pin to the last day of the last year
			if (y > YEAR_CEIL) begin
				y = YEAR_CEIL;
				m = 12;
				d = 31;
			end
		end
		wd           = jd % 7;
		r.day_number = jd[22:0];
		r.year       = y[14:0];
		r.month      = m[3:0];
		r.day        = d[4:0];
		r.weekday    = wd[2:0];
		return r;
	endfunction

	// Offer one request, hold it until accepted, then queue its prediction.
	// A gap of random length may go in front unless the run is quiet.
	task automatic send_request(input logic act, input logic cal,
			input logic signed [14:0] yr, input logic [3:0] mon,
			input logic [4:0] dy, input logic [22:0] dn);
		conv_request_t rq;
		conv_result_t  want;
		rq.action     = act;
		rq.calendar   = cal;
		rq.year       = yr;
		rq.month      = mon;
		rq.day        = dy;
		rq.day_number = dn;
		want          = convert_request(rq);
		if (!quiet_run && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {cal, act};
		s_tdata  <= {1'b0, dn, dy, mon, yr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_conversions.push_back(want);
		if (act == ACT_TO_DAY_NUMBER)
			dates_converted++;
		else
			numbers_converted++;
		if (act == ACT_TO_DATE && want.year == YEAR_CEIL[14:0] && dn > 23'd7704000)
			clamped_count++;
		if (act == ACT_TO_DAY_NUMBER &&
				(want.day_number == 23'd0 || want.day_number == DAY_NUMBER_CEIL[22:0]))
			clamped_count++;
	endtask

	// Send one request with every field random but the kind when force_date is set;
	// most values sit in the documented ranges, a fraction covers the full width of each field.
	task automatic send_random_request(input logic force_date);
		logic               act, cal;
		logic signed [14:0] yr;
		logic [3:0]         mon;
		logic [4:0]         dy;
		logic [22:0]        dn;
		act = force_date ? ACT_TO_DAY_NUMBER : logic'($urandom_range(0, 1));
		cal = logic'($urandom_range(0, 1));
		if ($urandom_range(0, 7) == 0)
			yr = 15'($urandom);
		else
			yr = 15'(int'($urandom_range(0, 14713)) - 4713);
		mon = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
		dy  = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
		case ($urandom_range(0, 7))
			0: begin
				dn = 23'($urandom);
			end
			1: begin
				dn = 23'($urandom_range(0, 4000));
			end
			default: begin
				dn = 23'($urandom_range(0, 5400000));
			end
		endcase
		send_request(act, cal, yr, mon, dy, dn);
	endtask

	// Known dates, field extremes, unchecked dates and both saturations.
	task automatic test_directed_dates();
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, 2000, 1, 1, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_JULIAN, 2000, 1, 1, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_JULIAN, -4713, 1, 1, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, -4713, 11, 24, 0);
		// far past the epoch: day number clamps to zero
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, -16384, 1, 1, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_JULIAN, -16384, 0, 0, 23'h7fffff);
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, 16383, 12, 31, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_JULIAN, 16383, 15, 31, 0);
		// month zero acts as December of the year before, day zero as the day before
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, 2024, 0, 0, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_JULIAN, 1582, 10, 4, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, 1582, 10, 15, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_GREGORIAN, 2023, 2, 31, 0);
		send_request(ACT_TO_DAY_NUMBER, CAL_JULIAN, 10000, 13, 5, 0);
		send_request(ACT_TO_DATE, CAL_JULIAN, 0, 0, 0, 0);
		send_request(ACT_TO_DATE, CAL_GREGORIAN, 0, 0, 0, 0);
		send_request(ACT_TO_DATE, CAL_JULIAN, 16383, 15, 31, 1);
		send_request(ACT_TO_DATE, CAL_GREGORIAN, 0, 1, 1, 2451545);
		send_request(ACT_TO_DATE, CAL_JULIAN, 0, 1, 1, 2299160);
		send_request(ACT_TO_DATE, CAL_GREGORIAN, 0, 1, 1, 2299161);
		send_request(ACT_TO_DATE, CAL_GREGORIAN, 0, 1, 1, 5400000);
		send_request(ACT_TO_DATE, CAL_JULIAN, 0, 1, 1, 5373484);
		// years past the output range pin to 16383-12-31
		send_request(ACT_TO_DATE, CAL_GREGORIAN, 0, 1, 1, 7800000);
		send_request(ACT_TO_DATE, CAL_GREGORIAN, -1, 15, 31, 23'h7fffff);
		send_request(ACT_TO_DATE, CAL_JULIAN, -1, 15, 31, 23'h7fffff);
	endtask

	// Hold the result side for a long stretch while requests keep coming, so
	// the output register fills and the input stalls; wait for the release.
	task automatic test_output_backpressure();
		long_hold_req = 1'b1;
		repeat (6)
			send_random_request(1'b1);
		while (long_hold_req)
			@(posedge clk);
	endtask

	task automatic test_random_mix(input int count);
		repeat (count)
			send_random_request(1'b0);
	endtask

	// Last part: no gaps on either side, requests back to back.
	task automatic test_random_back_to_back(input int count);
		quiet_run = 1'b1;
		repeat (count)
			send_random_request(1'b0);
	endtask

	// Result side: random stall bursts, one long hold on request, none when quiet.
	initial begin
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
				long_hold_req = 1'b0;
			end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : result_check
		conv_result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.day_number = m_tdata[22:0];
			got.year       = m_tdata[37:23];
			got.month      = m_tdata[41:38];
			got.day        = m_tdata[46:42];
			got.weekday    = m_tdata[49:47];
			results_checked++;
			if (pending_conversions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result with nothing expected: jd=%0d %0d-%0d-%0d wd=%0d",
						$realtime, got.day_number, got.year, got.month, got.day, got.weekday);
			end else begin
				want = pending_conversions.pop_front();
				if (want.day_number !== got.day_number || want.year !== got.year ||
						want.month !== got.month || want.day !== got.day ||
						want.weekday !== got.weekday) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: expected jd=%0d %0d-%0d-%0d wd=%0d, got jd=%0d %0d-%0d-%0d wd=%0d",
							$realtime, want.day_number, want.year, want.month, want.day,
							want.weekday, got.day_number, got.year, got.month, got.day,
							got.weekday);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_dates();
		test_output_backpressure();
		test_random_mix(1400);
		test_random_back_to_back(320);

		// drain: drop valid, wait for every owed result, then a settling margin
		s_tvalid <= 1'b0;
		while (pending_conversions.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Converted %0d dates to day numbers and %0d day numbers to dates,",
			dates_converted, numbers_converted);
		$display("%0d results checked, %0d requests hit a clamp, with stalls on both sides.",
			results_checked, clamped_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
